FILE: hdl/gkes_pkg.sv
package gkes_pkg;

  localparam int NUM_POINTS_DEF  = 33;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int IDX_W           = 6;
  localparam int LEVEL_W         = 16;
  localparam int REG_W           = 16;
  localparam int Q15_SHIFT       = 15;

  localparam logic [REG_W-1:0] ALPHA_LOW    = 16'd328;
  localparam logic [REG_W-1:0] ALPHA_HIGH   = 16'd32768;
  localparam logic [REG_W-1:0] ALPHA_RESET  = 16'd16384;
  localparam logic [REG_W-1:0] THRESH_HIGH  = 16'd32768;
  localparam logic [REG_W-1:0] THRESH_RESET = 16'd16384;
  localparam logic [REG_W-1:0] Q15_HALF     = 16'd16384;

  localparam logic REG_ALPHA  = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  typedef struct packed {
    logic clear;
    logic in_range;
    logic gate;
  } ctl_t;

  localparam int CTL_W = $bits(ctl_t);

endpackage

FILE: hdl/gkes_front.sv
module gkes_front #(
  parameter int NUM_POINTS  = gkes_pkg::NUM_POINTS_DEF,
  parameter int COORD_WIDTH = gkes_pkg::COORD_WIDTH_DEF,
  parameter int ENTRY_W     = gkes_pkg::CTL_W + gkes_pkg::IDX_W + 3 * COORD_WIDTH
                              + gkes_pkg::LEVEL_W
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              write_enable,
  input  logic                              reg_index,
  input  logic [gkes_pkg::REG_W-1:0]        write_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic [gkes_pkg::IDX_W-1:0]        point_index,
  input  logic signed [COORD_WIDTH-1:0]     coord_x,
  input  logic signed [COORD_WIDTH-1:0]     coord_y,
  input  logic signed [COORD_WIDTH-1:0]     coord_z,
  input  logic [gkes_pkg::LEVEL_W-1:0]      seen_level,
  input  logic                              q_full,
  output logic                              q_push,
  output logic [ENTRY_W-1:0]                q_data,
  output logic [gkes_pkg::REG_W-1:0]        alpha
);
  import gkes_pkg::*;

  logic [REG_W-1:0] threshold;
  ctl_t             ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha     <= ALPHA_RESET;
      threshold <= THRESH_RESET;
    end else if (write_enable) begin
      case (reg_index)
        REG_ALPHA: begin
          if (write_data < ALPHA_LOW) begin
            alpha <= ALPHA_LOW;
          end else if (write_data > ALPHA_HIGH) begin
            alpha <= ALPHA_HIGH;
          end else begin
            alpha <= write_data;
          end
        end
        REG_THRESH: begin
          if (write_data > THRESH_HIGH) begin
            threshold <= THRESH_HIGH;
          end else begin
            threshold <= write_data;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    ctl.clear    = action;
    ctl.in_range = {1'b0, point_index} < (IDX_W + 1)'(NUM_POINTS);
    ctl.gate     = seen_level >= threshold;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_data   = {ctl, point_index, coord_x, coord_y, coord_z, seen_level};

endmodule

FILE: hdl/gkes_queue.sv
module gkes_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: hdl/gkes_back.sv
module gkes_back #(
  parameter int NUM_POINTS  = gkes_pkg::NUM_POINTS_DEF,
  parameter int COORD_WIDTH = gkes_pkg::COORD_WIDTH_DEF,
  parameter int ENTRY_W     = gkes_pkg::CTL_W + gkes_pkg::IDX_W + 3 * COORD_WIDTH
                              + gkes_pkg::LEVEL_W
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [gkes_pkg::REG_W-1:0]        alpha,
  input  logic                              q_empty,
  input  logic [ENTRY_W-1:0]                q_head,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gkes_pkg::IDX_W-1:0]        result_index,
  output logic signed [COORD_WIDTH-1:0]     smooth_x,
  output logic signed [COORD_WIDTH-1:0]     smooth_y,
  output logic signed [COORD_WIDTH-1:0]     smooth_z,
  output logic [gkes_pkg::LEVEL_W-1:0]      result_visibility
);
  import gkes_pkg::*;

  localparam int AW    = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam int CW    = COORD_WIDTH;
  localparam int PW    = CW + 18;
  localparam int SW    = CW + 4;
  localparam int HW    = 3 * CW;

  function automatic logic signed [CW-1:0] ema_step(
    input logic signed [CW-1:0] h,
    input logic signed [CW-1:0] c,
    input logic [REG_W-1:0]     a
  );
    logic signed [CW:0]   diff;
    logic signed [PW-1:0] prod;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] sat_max;
    logic signed [SW-1:0] sat_min;
    diff    = $signed({c[CW-1], c}) - $signed({h[CW-1], h});
    prod    = diff * $signed({1'b0, a});
    prod    = prod + $signed(PW'(Q15_HALF));
    sum     = $signed({prod[PW-1], prod[PW-1:Q15_SHIFT]}) + $signed({{4{h[CW-1]}}, h});
    sat_max = $signed({5'b00000, {(CW - 1){1'b1}}});
    sat_min = $signed({5'b11111, {(CW - 1){1'b0}}});
    if (sum > sat_max) begin
      ema_step = sat_max[CW-1:0];
    end else if (sum < sat_min) begin
      ema_step = sat_min[CW-1:0];
    end else begin
      ema_step = sum[CW-1:0];
    end
  endfunction

  ctl_t                h_ctl;
  logic [IDX_W-1:0]    h_idx;
  logic [HW-1:0]       h_coords;
  logic [LEVEL_W-1:0]  h_level;

  logic                s2_valid;
  ctl_t                s2_ctl;
  logic [IDX_W-1:0]    s2_idx;
  logic [HW-1:0]       s2_coords;
  logic [LEVEL_W-1:0]  s2_level;
  logic                s2_fire;

  logic [HW-1:0]       hist [NUM_POINTS];
  logic [HW-1:0]       hist_rd;
  logic [NUM_POINTS-1:0] seen;
  logic                seen_cur;

  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic                wr_en;
  logic [HW-1:0]       wr_data;
  logic [HW-1:0]       res_data;
  logic                show;

  logic signed [CW-1:0] h_lane [3];
  logic signed [CW-1:0] c_lane [3];
  logic signed [CW-1:0] n_lane [3];

  assign {h_ctl, h_idx, h_coords, h_level} = q_head;

  assign s2_fire = s2_valid && (s2_ctl.clear || !out_valid || !out_stall);
  assign q_pop   = !q_empty && (!s2_valid || s2_fire);
  assign rd_addr = h_idx[AW-1:0];
  assign wr_addr = s2_idx[AW-1:0];
  assign seen_cur = s2_ctl.in_range ? seen[wr_addr] : 1'b0;
  assign wr_en   = s2_fire && !s2_ctl.clear && s2_ctl.in_range && s2_ctl.gate;
  assign show    = s2_ctl.in_range && (seen_cur || s2_ctl.gate);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      h_lane[k] = hist_rd[(2 - k) * CW +: CW];
      c_lane[k] = s2_coords[(2 - k) * CW +: CW];
      n_lane[k] = seen_cur ? ema_step(h_lane[k], c_lane[k], alpha) : c_lane[k];
    end
    wr_data  = {n_lane[0], n_lane[1], n_lane[2]};
    res_data = '0;
    if (show) begin
      res_data = s2_ctl.gate ? wr_data : hist_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        hist_rd <= wr_data;
      end else begin
        hist_rd <= hist[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (q_pop) begin
      s2_valid <= 1'b1;
    end else if (s2_fire) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_ctl    <= h_ctl;
      s2_idx    <= h_idx;
      s2_coords <= h_coords;
      s2_level  <= h_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (s2_fire && s2_ctl.clear) begin
      seen <= '0;
    end else if (wr_en) begin
      seen[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_fire && !s2_ctl.clear) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && !s2_ctl.clear) begin
      result_index      <= s2_idx;
      smooth_x          <= res_data[2 * CW +: CW];
      smooth_y          <= res_data[CW +: CW];
      smooth_z          <= res_data[0 +: CW];
      result_visibility <= s2_level;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> (!out_valid && !s2_valid))
    else $error("pipeline not idle after reset");

  a_clear_forgets: assert property (@(posedge clk) disable iff (rst)
    (s2_fire && s2_ctl.clear) |=> (seen == '0))
    else $error("clear left a point marked seen");

  a_write_marks: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> seen[$past(wr_addr)])
    else $error("updated point not marked seen");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_fire) |=> (s2_valid && $stable(s2_idx) && $stable(s2_ctl)))
    else $error("stalled item lost in compute stage");

endmodule

FILE: hdl/gated_keypoint_ema_smoother_unit.sv
// Throughput: one item per cycle while in_stall is low; one result per smooth
// item, none per clear. Items go from the queue to out_valid via one EMA stage
// that reads history, multiplies and writes back with read forwarding.
// Reset clears the queue, the compute stage, out_valid and every seen bit,
// and loads alpha and threshold with 16384; history needs no clearing pass.
module gated_keypoint_ema_smoother_unit #(
  parameter int NUM_POINTS  = gkes_pkg::NUM_POINTS_DEF,
  parameter int COORD_WIDTH = gkes_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              write_enable,
  input  logic                              reg_index,
  input  logic [gkes_pkg::REG_W-1:0]        write_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic [gkes_pkg::IDX_W-1:0]        point_index,
  input  logic signed [COORD_WIDTH-1:0]     coord_x,
  input  logic signed [COORD_WIDTH-1:0]     coord_y,
  input  logic signed [COORD_WIDTH-1:0]     coord_z,
  input  logic [gkes_pkg::LEVEL_W-1:0]      seen_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gkes_pkg::IDX_W-1:0]        result_index,
  output logic signed [COORD_WIDTH-1:0]     smooth_x,
  output logic signed [COORD_WIDTH-1:0]     smooth_y,
  output logic signed [COORD_WIDTH-1:0]     smooth_z,
  output logic [gkes_pkg::LEVEL_W-1:0]      result_visibility
);
  import gkes_pkg::*;

  localparam int ENTRY_W = CTL_W + IDX_W + 3 * COORD_WIDTH + LEVEL_W;

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_data;
  logic [ENTRY_W-1:0] q_head;
  logic [REG_W-1:0]   alpha;

  gkes_front #(
    .NUM_POINTS  (NUM_POINTS),
    .COORD_WIDTH (COORD_WIDTH),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .point_index  (point_index),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .coord_z      (coord_z),
    .seen_level   (seen_level),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_data),
    .alpha        (alpha)
  );

  gkes_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  gkes_back #(
    .NUM_POINTS  (NUM_POINTS),
    .COORD_WIDTH (COORD_WIDTH),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .alpha             (alpha),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .result_index      (result_index),
    .smooth_x          (smooth_x),
    .smooth_y          (smooth_y),
    .smooth_z          (smooth_z),
    .result_visibility (result_visibility)
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gkes_pkg::*;

  localparam int NPTS = NUM_POINTS_DEF;
  localparam int CW = COORD_WIDTH_DEF;
  localparam logic ACT_SMOOTH = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;
  localparam int QUIET_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 400;

  typedef struct {
    logic act;
    logic [IDX_W-1:0] idx;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [LEVEL_W-1:0] vis;
  } kp_item_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [LEVEL_W-1:0] vis;
  } kp_result_t;

  class keypoint_ema_board;
    logic [REG_W-1:0] alpha;
    logic [REG_W-1:0] thresh;
    logic signed [CW-1:0] track_x[NPTS];
    logic signed [CW-1:0] track_y[NPTS];
    logic signed [CW-1:0] track_z[NPTS];
    bit seen[NPTS];
    kp_result_t smoothed_due[$];
    int mismatches;

    function new();
      alpha = ALPHA_RESET;
      thresh = THRESH_RESET;
      mismatches = 0;
      forget_all();
    endfunction

    function void forget_all();
      for (int i = 0; i < NPTS; i++) begin
        track_x[i] = '0;
        track_y[i] = '0;
        track_z[i] = '0;
        seen[i] = 1'b0;
      end
    endfunction

    function void set_reg(logic ri, logic [REG_W-1:0] d);
      if (ri == REG_ALPHA) begin
        if (d < ALPHA_LOW) alpha = ALPHA_LOW;
        else if (d > ALPHA_HIGH) alpha = ALPHA_HIGH;
        else alpha = d;
      end else begin
        thresh = (d > THRESH_HIGH) ? THRESH_HIGH : d;
      end
    endfunction

    function logic signed [CW-1:0] ema_move(logic signed [CW-1:0] h, logic signed [CW-1:0] c);
      longint cmax;
      longint p;
      longint q;
      cmax = (longint'(1) <<< (CW - 1)) - 1;
      p = longint'(alpha) * (longint'(c) - longint'(h)) + longint'(Q15_HALF);
      q = (p >>> Q15_SHIFT) + longint'(h);
      if (q > cmax) q = cmax;
      if (q < -cmax - 1) q = -cmax - 1;
      return q[CW-1:0];
    endfunction

    function int pending();
      return smoothed_due.size();
    endfunction

    function void take_sample(kp_item_t it);
      kp_result_t r;
      if (it.act == ACT_CLEAR) begin
        forget_all();
        return;
      end
      r.idx = it.idx;
      r.x = '0;
      r.y = '0;
      r.z = '0;
      r.vis = it.vis;
      if (it.idx < NPTS) begin
        if (it.vis >= thresh) begin
          if (!seen[it.idx]) begin
            track_x[it.idx] = it.x;
            track_y[it.idx] = it.y;
            track_z[it.idx] = it.z;
            seen[it.idx] = 1'b1;
          end else begin
            track_x[it.idx] = ema_move(track_x[it.idx], it.x);
            track_y[it.idx] = ema_move(track_y[it.idx], it.y);
            track_z[it.idx] = ema_move(track_z[it.idx], it.z);
          end
        end
        if (seen[it.idx]) begin
          r.x = track_x[it.idx];
          r.y = track_y[it.idx];
          r.z = track_z[it.idx];
        end
      end
      smoothed_due.push_back(r);
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_smoothed(kp_result_t got);
      kp_result_t e;
      if (smoothed_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result idx=%0d x=%0d y=%0d z=%0d vis=%0d",
                                got.idx, got.x, got.y, got.z, got.vis));
        return;
      end
      e = smoothed_due.pop_front();
      if (got.idx !== e.idx || got.x !== e.x || got.y !== e.y || got.z !== e.z ||
          got.vis !== e.vis)
        note_mismatch($sformatf({"result mismatch: expected idx=%0d x=%0d y=%0d z=%0d vis=%0d,",
                                 " got idx=%0d x=%0d y=%0d z=%0d vis=%0d"},
                                e.idx, e.x, e.y, e.z, e.vis,
                                got.idx, got.x, got.y, got.z, got.vis));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic write_enable = 1'b0;
  logic reg_index = REG_ALPHA;
  logic [REG_W-1:0] write_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = ACT_SMOOTH;
  logic [IDX_W-1:0] point_index = '0;
  logic signed [CW-1:0] coord_x = '0;
  logic signed [CW-1:0] coord_y = '0;
  logic signed [CW-1:0] coord_z = '0;
  logic [LEVEL_W-1:0] seen_level = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IDX_W-1:0] result_index;
  logic signed [CW-1:0] smooth_x;
  logic signed [CW-1:0] smooth_y;
  logic signed [CW-1:0] smooth_z;
  logic [LEVEL_W-1:0] result_visibility;

  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  keypoint_ema_board board = new();

  gated_keypoint_ema_smoother_unit u_top (
    .clk(clk),
    .rst(rst),
    .write_enable(write_enable),
    .reg_index(reg_index),
    .write_data(write_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .point_index(point_index),
    .coord_x(coord_x),
    .coord_y(coord_y),
    .coord_z(coord_z),
    .seen_level(seen_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_index(result_index),
    .smooth_x(smooth_x),
    .smooth_y(smooth_y),
    .smooth_z(smooth_z),
    .result_visibility(result_visibility)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        board.check_smoothed('{result_index, smooth_x, smooth_y, smooth_z, result_visibility});
      if (in_valid && !in_stall)
        board.take_sample('{action, point_index, coord_x, coord_y, coord_z, seen_level});
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic kp_item_t pt(logic [IDX_W-1:0] idx, logic signed [CW-1:0] x,
                                  logic signed [CW-1:0] y, logic signed [CW-1:0] z,
                                  logic [LEVEL_W-1:0] vis);
    kp_item_t it;
    it = '{ACT_SMOOTH, idx, x, y, z, vis};
    return it;
  endfunction

  function automatic logic signed [CW-1:0] pick_coord(logic [IDX_W-1:0] idx, int mode,
                                                      logic signed [CW-1:0] hist);
    if (mode < 4 && idx < NPTS && board.seen[idx])
      return hist + CW'($urandom_range(0, 64)) - CW'(32);
    if (mode < 6)
      return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
    return CW'($urandom);
  endfunction

  function automatic kp_item_t random_item();
    kp_item_t it;
    int mode;
    logic [IDX_W-1:0] i;
    it.act = ($urandom_range(0, 99) < 2) ? ACT_CLEAR : ACT_SMOOTH;
    if ($urandom_range(0, 99) < 8) it.idx = IDX_W'($urandom_range(NPTS, 63));
    else it.idx = IDX_W'($urandom_range(0, NPTS - 1));
    i = (it.idx < NPTS) ? it.idx : '0;
    mode = $urandom_range(0, 9);
    it.x = pick_coord(it.idx, mode, board.track_x[i]);
    it.y = pick_coord(it.idx, mode, board.track_y[i]);
    it.z = pick_coord(it.idx, mode, board.track_z[i]);
    case ($urandom_range(0, 9))
      0: it.vis = '0;
      1: it.vis = board.thresh - 1'b1;
      2: it.vis = board.thresh;
      3: it.vis = '1;
      4, 5: it.vis = LEVEL_W'($urandom);
      default: it.vis = LEVEL_W'($urandom_range(board.thresh, 32768));
    endcase
    return it;
  endfunction

  task automatic send_item(kp_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= it.act;
    point_index <= it.idx;
    coord_x <= it.x;
    coord_y <= it.y;
    coord_z <= it.z;
    seen_level <= it.vis;
    do @(posedge clk); while (in_stall);
  endtask

  // drain, then let a trailing clear finish before touching registers
  task automatic write_regs(logic [REG_W-1:0] alpha_val, logic [REG_W-1:0] thresh_val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    write_enable <= 1'b1;
    reg_index <= REG_ALPHA;
    write_data <= alpha_val;
    @(posedge clk);
    board.set_reg(REG_ALPHA, alpha_val);
    @(negedge clk);
    reg_index <= REG_THRESH;
    write_data <= thresh_val;
    @(posedge clk);
    board.set_reg(REG_THRESH, thresh_val);
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  initial begin
    logic [REG_W-1:0] a_val;
    logic [REG_W-1:0] t_val;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(pt(0, 32767, -32768, 0, 32768));
    send_item(pt(0, -32768, 32767, -1, 16'hFFFF));
    send_item(pt(0, 0, 0, 0, 0));
    send_item(pt(0, 5, -5, 1, 16384));
    send_item(pt(1, 100, 200, 300, 16383));
    send_item(pt(1, 100, 200, 300, 16384));
    send_item(pt(1, 101, 199, 301, 20000));
    send_item(pt(32, -1, -1, -1, 32768));
    send_item(pt(33, 1234, -1234, 77, 65535));
    send_item(pt(63, -1, 32767, -32768, 40000));
    send_item('{ACT_CLEAR, 6'd63, -1, -1, -1, 16'hFFFF});
    send_item(pt(0, 9, 9, 9, 0));
    send_item(pt(32, 32767, 32767, 32767, 65535));
    write_regs(16'd0, 16'd0);
    send_item(pt(32, -32768, -32768, -32768, 0));
    send_item(pt(2, -7, 7, 3, 0));
    send_item(pt(2, 32767, -32768, 1, 1));
    write_regs(16'hFFFF, 16'hFFFF);
    send_item(pt(2, 0, 0, 0, 32767));
    send_item(pt(2, 1, -1, 2, 32768));
    write_regs(ALPHA_LOW, THRESH_HIGH);
    send_item(pt(2, -32768, 32767, -32768, 32768));
    send_item(pt(32, 1, 1, 1, 32768));
    write_regs(ALPHA_HIGH, 16'd1);
    send_item(pt(3, 4096, -4096, 0, 1));
    send_item(pt(3, -4096, 4096, 12, 2));

    for (int ph = 0; ph < 4; ph++) begin
      case ($urandom_range(0, 4))
        0: a_val = '0;
        1: a_val = ALPHA_LOW;
        2: a_val = ALPHA_HIGH;
        3: a_val = '1;
        default: a_val = REG_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: t_val = '0;
        1: t_val = THRESH_HIGH;
        2: t_val = '1;
        default: t_val = REG_W'($urandom_range(0, 32768));
      endcase
      write_regs(a_val, t_val);
      idle_pct = (ph == 1 || ph == 3) ? 72 : 0;
      stall_pct = (ph == 2) ? 72 : (ph == 3) ? 28 : 0;
      if (ph == 3) idle_pct = 28;
      repeat (ITEMS_PER_PHASE) send_item(random_item());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    stall_pct = 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
